// ----- src/wavg_pkg.sv -----
// Package for the windowed average block: shared widths, operation and
// register codes, and the command/status structs between controller and datapath.
// No dependencies.
package wavg_pkg;

  localparam int RING_DEPTH_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int TIME_BITS       = 32;
  localparam int AGE_BITS        = 31;
  localparam int AVG_CFG_BITS    = 5;
  localparam int OP_BITS         = 2;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = AGE_BITS;

  typedef logic [OP_BITS-1:0] op_t;
  localparam op_t OP_UPDATE = 2'd0;
  localparam op_t OP_STEP   = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAX_AGE   = 1'b0;
  localparam cfg_idx_t CFG_AVG_COUNT = 1'b1;

  typedef struct packed {
    logic capture;
    logic apply_simple;
    logic ring_write;
    logic read_step;
    logic div_start;
    logic div_step;
    logic div_finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic avg_update;
    logic sum_done;
    logic div_done;
  } status_t;

endpackage

// ----- src/windowed_average_with_timeout.sv -----
// Top level of the windowed average with timeout block.
// Depends on wavg_pkg, wavg_ctrl, wavg_dp and wavg_ram.
//
// Usage:
//   Input channel in_*: tuser carries the operation (update, step, clear),
//   tdata carries sample and time. One result per item leaves on out_*, with
//   the current value in tdata and the valid flag in tuser.
//   Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; the user
//   must make them only while the block is idle, which the block itself
//   does not enforce; cfg_ready is always high. The block works on one item
//   at a time. A step, a clear or a pass-through update passes from the
//   capture register through the decode and done states to the output
//   register. An averaging update reads the ring one entry per cycle through
//   its single read port, summing the newest averaged samples, and the
//   divider then yields one quotient bit per cycle.
//   A new item is accepted the cycle after the previous result is loaded,
//   even while that result still waits on a stalled receiver; the output
//   register holds it until out_tready. If the receiver stays stalled, the
//   next result waits inside the block and in_tready stays low.
//   Synchronous reset clears the value, flag, ring index, fill count, last
//   update time and both configuration registers; ring contents stay unknown.
module windowed_average_with_timeout #(
  parameter int RING_DEPTH  = wavg_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + wavg_pkg::TIME_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  wavg_pkg::cfg_idx_t                 cfg_index,
  input  logic [wavg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_DATA_W-1:0]               in_tdata,  // sample, time_ms, zero pad
  input  wavg_pkg::op_t                      in_tuser,  // op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OUT_DATA_W-1:0]              out_tdata, // value, zero pad
  output logic                               out_tuser  // valid_res
);
  import wavg_pkg::*;

  cmd_t                          cmd;
  status_t                       st;
  logic signed [SAMPLE_BITS-1:0] value;

  assign cfg_ready = 1'b1;

  wavg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  wavg_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (in_tuser),
    .in_sample     (in_tdata[SAMPLE_BITS-1:0]),
    .in_time_ms    (in_tdata[SAMPLE_BITS +: TIME_BITS]),
    .cmd           (cmd),
    .st            (st),
    .out_value     (value),
    .out_valid_res (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(unsigned'(value));

endmodule

// ----- src/wavg_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module wavg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/wavg_ctrl.sv -----
// Controller state machine for the windowed average block.
// Depends on wavg_pkg for the command and status structs.
module wavg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  wavg_pkg::status_t st,
  output wavg_pkg::cmd_t    cmd
);
  import wavg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.avg_update) begin
          cmd.ring_write = 1'b1;
          state_nxt      = S_READ;
        end else begin
          cmd.apply_simple = 1'b1;
          state_nxt        = S_DONE;
        end
      end
      S_READ: begin
        if (st.sum_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.read_step = 1'b1;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.div_finish = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output slot is refilled in the same cycle the receiver takes the old result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- src/wavg_dp.sv -----
// Datapath of the windowed average block: configuration and state registers,
// sample ring, accumulator, serial divider and output register.
// Depends on wavg_pkg and wavg_ram.
module wavg_dp #(
  parameter int RING_DEPTH  = wavg_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  wavg_pkg::cfg_idx_t                   cfg_index,
  input  logic [wavg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wavg_pkg::op_t                        in_op,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic [wavg_pkg::TIME_BITS-1:0]       in_time_ms,
  input  wavg_pkg::cmd_t                       cmd,
  output wavg_pkg::status_t                    st,
  output logic signed [SAMPLE_BITS-1:0]        out_value,
  output logic                                 out_valid_res
);
  import wavg_pkg::*;

  localparam int IW       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW       = $clog2(RING_DEPTH + 1);
  localparam int SUM_BITS = SAMPLE_BITS + CW;
  localparam int DCW      = $clog2(SUM_BITS + 1);

  // Configuration.
  logic [AGE_BITS-1:0] max_age_r;
  logic [CW-1:0]       avg_r;
  logic [AVG_CFG_BITS-1:0] avg_wr;

  // Captured item.
  op_t                          op_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic [TIME_BITS-1:0]          time_r;

  // Block state.
  logic [IW-1:0]                 wi_r, wi_nxt;
  logic [CW-1:0]                 fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic                          set_r, set_nxt;
  logic [TIME_BITS-1:0]          last_r, last_nxt;

  // Summation and division.
  logic [IW-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]                 rd_left_r, rd_left_nxt;
  logic                          rvalid_r, rvalid_nxt;
  logic [CW-1:0]                 n_r, n_nxt;
  logic signed [SUM_BITS-1:0]    acc_r, acc_nxt;
  logic [SUM_BITS-1:0]           quo_r, quo_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic [DCW-1:0]                div_cnt_r, div_cnt_nxt;

  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic                          out_valid_r;

  logic                          ram_re;
  logic [SAMPLE_BITS-1:0]        ram_rdata;

  // Combinational helpers.
  logic [TIME_BITS-1:0] age;
  logic                 expired;
  logic [CW-1:0]        fill_inc, n_new;
  logic [IW-1:0]        wi_inc;
  logic [CW:0]          rem_sh;
  logic                 rem_ge;
  logic [SAMPLE_BITS-1:0] q_small;

  wavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.ring_write),
    .waddr (wi_r),
    .wdata (smp_r),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign avg_wr = cfg_data[AVG_CFG_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= '0;
      avg_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_AGE:   max_age_r <= cfg_data[AGE_BITS-1:0];
        CFG_AVG_COUNT: begin
          if (32'(avg_wr) > 32'(RING_DEPTH)) begin
            avg_r <= CW'(RING_DEPTH);
          end else begin
            avg_r <= CW'(avg_wr);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      smp_r  <= in_sample;
      time_r <= in_time_ms;
    end
  end

  // A negative age, top bit set, never expires the value.
  assign age     = time_r - last_r;
  assign expired = (max_age_r != '0) && !age[TIME_BITS-1]
                   && (age[AGE_BITS-1:0] > max_age_r);

  assign wi_inc   = (wi_r == IW'(RING_DEPTH - 1)) ? '0 : wi_r + IW'(1);
  assign fill_inc = (fill_r < avg_r) ? fill_r + CW'(1) : fill_r;
  assign n_new    = (fill_inc < avg_r) ? fill_inc : avg_r;

  assign ram_re = cmd.read_step && (rd_left_r != '0);

  assign rem_sh  = {rem_r, quo_r[SUM_BITS-1]};
  assign rem_ge  = rem_sh >= {1'b0, n_r};
  assign q_small = quo_r[SAMPLE_BITS-1:0];

  always_comb begin
    wi_nxt      = wi_r;
    fill_nxt    = fill_r;
    cur_nxt     = cur_r;
    set_nxt     = set_r;
    last_nxt    = last_r;
    rd_ptr_nxt  = rd_ptr_r;
    rd_left_nxt = rd_left_r;
    rvalid_nxt  = rvalid_r;
    n_nxt       = n_r;
    acc_nxt     = acc_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    neg_nxt     = neg_r;
    div_cnt_nxt = div_cnt_r;

    if (cmd.apply_simple) begin
      case (op_r)
        OP_UPDATE: begin
          cur_nxt  = smp_r;
          last_nxt = time_r;
          set_nxt  = 1'b1;
        end
        OP_STEP: begin
          if (expired) begin
            cur_nxt  = '0;
            set_nxt  = 1'b0;
            wi_nxt   = '0;
            fill_nxt = '0;
          end
        end
        OP_CLEAR: begin
          cur_nxt  = '0;
          set_nxt  = 1'b0;
          wi_nxt   = '0;
          fill_nxt = '0;
        end
        default: ;
      endcase
    end

    // The new sample sits at the old write index; the sum walks backward from it.
    if (cmd.ring_write) begin
      wi_nxt      = wi_inc;
      fill_nxt    = fill_inc;
      n_nxt       = n_new;
      rd_ptr_nxt  = wi_r;
      rd_left_nxt = n_new;
      rvalid_nxt  = 1'b0;
      acc_nxt     = '0;
      last_nxt    = time_r;
      set_nxt     = 1'b1;
    end

    if (cmd.read_step) begin
      rvalid_nxt = ram_re;
      if (ram_re) begin
        rd_ptr_nxt  = (rd_ptr_r == '0) ? IW'(RING_DEPTH - 1) : rd_ptr_r - IW'(1);
        rd_left_nxt = rd_left_r - CW'(1);
      end
      if (rvalid_r) begin
        acc_nxt = acc_r + {{CW{ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
      end
    end

    if (cmd.div_start) begin
      neg_nxt     = acc_r[SUM_BITS-1];
      quo_nxt     = acc_r[SUM_BITS-1] ? SUM_BITS'(-acc_r) : SUM_BITS'(acc_r);
      rem_nxt     = '0;
      div_cnt_nxt = DCW'(SUM_BITS);
    end

    // Restoring division, one quotient bit per cycle.
    if (cmd.div_step) begin
      rem_nxt     = rem_ge ? CW'(rem_sh - {1'b0, n_r}) : rem_sh[CW-1:0];
      quo_nxt     = {quo_r[SUM_BITS-2:0], rem_ge};
      div_cnt_nxt = div_cnt_r - DCW'(1);
    end

    if (cmd.div_finish) begin
      cur_nxt = neg_r ? -$signed(q_small) : $signed(q_small);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r      <= '0;
      fill_r    <= '0;
      cur_r     <= '0;
      set_r     <= 1'b0;
      last_r    <= '0;
      rd_left_r <= '0;
      rvalid_r  <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      wi_r      <= wi_nxt;
      fill_r    <= fill_nxt;
      cur_r     <= cur_nxt;
      set_r     <= set_nxt;
      last_r    <= last_nxt;
      rd_left_r <= rd_left_nxt;
      rvalid_r  <= rvalid_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    n_r      <= n_nxt;
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    neg_r    <= neg_nxt;
    if (cmd.load_out) begin
      out_value_r <= cur_r;
      out_valid_r <= set_r;
    end
  end

  assign st.avg_update = (op_r == OP_UPDATE) && (avg_r != '0);
  assign st.sum_done   = (rd_left_r == '0) && !rvalid_r;
  assign st.div_done   = (div_cnt_r == '0);

  assign out_value     = out_value_r;
  assign out_valid_res = out_valid_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(RING_DEPTH))
    else $error("fill count exceeds ring depth");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !set_r |-> (cur_r == '0))
    else $error("value not zero while flag is clear");

  a_write_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ring_write |=> (set_r && (fill_r != '0) && (rd_left_r != '0)))
    else $error("ring write left no averaging work");

  a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_finish |-> ((quo_r >> SAMPLE_BITS) == '0))
    else $error("average magnitude does not fit the sample width");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for windowed_average_with_timeout: a directed stimulus table, then
// randomized phases under several register settings, all checked in order.
// Depends on wavg_pkg and the windowed_average_with_timeout RTL.
module tb_top;
  import wavg_pkg::*;

  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int DEPTH       = RING_DEPTH_DEF;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int IN_W        = ((SW + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((SW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 250;
  localparam op_t OP_UNUSED  = 2'd3;

  typedef logic signed [SW-1:0] q_t;
  typedef logic [TIME_BITS-1:0] ms_t;
  typedef logic [AGE_BITS-1:0]  age_t;

  typedef struct packed {
    q_t   value;
    logic flag;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // Register rows carry their write data in the time column.
  typedef struct packed {
    row_kind_t kind;
    op_t       op;
    cfg_idx_t  idx;
    q_t        smp;
    ms_t       t;
    logic      typed;
    q_t        wv;
    logic      wf;
  } row_t;

  localparam int ROWS = 33;
  localparam row_t PLAN [ROWS] = '{
    '{ROW_CFG,  OP_UPDATE, CFG_MAX_AGE,   24'h000000, 32'd10,       1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'd10,       1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'd11,       1'b1, 24'h000000, 1'b0},
    '{ROW_CFG,  OP_UPDATE, CFG_MAX_AGE,   24'h000000, 32'd0,        1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UNUSED, CFG_MAX_AGE,   24'h7FFFFF, 32'd5,        1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h7FFFFF, 32'd100,      1'b1, 24'h7FFFFF, 1'b1},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h800000, 32'd200,      1'b1, 24'h800000, 1'b1},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'hFFFFFFFF, 1'b1, 24'h800000, 1'b1},
    '{ROW_ITEM, OP_UNUSED, CFG_MAX_AGE,   24'h000000, 32'h00000000, 1'b1, 24'h800000, 1'b1},
    '{ROW_ITEM, OP_CLEAR,  CFG_MAX_AGE,   24'h000000, 32'd300,      1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'hFFFFFF, 32'hFFFFFC17, 1'b1, 24'hFFFFFF, 1'b1},
    '{ROW_CFG,  OP_UPDATE, CFG_MAX_AGE,   24'h000000, 32'd1000,     1'b0, 24'h000000, 1'b0},
    '{ROW_CFG,  OP_UPDATE, CFG_AVG_COUNT, 24'h000000, 32'd4,        1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 1'b1},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'h00000000, 1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'h00000000, 1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h7FFFFF, 32'd2000,     1'b1, 24'h7FFFFF, 1'b1},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h7FFFFF, 32'd2001,     1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h800000, 32'd2002,     1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h800000, 32'd2003,     1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'hFFFFFF, 32'd2004,     1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'h800007D4, 1'b0, 24'h000000, 1'b0},
    '{ROW_CFG,  OP_UPDATE, CFG_MAX_AGE,   24'h000000, 32'h7FFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_CFG,  OP_UPDATE, CFG_AVG_COUNT, 24'h000000, 32'h7FFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h000001, 32'd3000,     1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'h80000BB7, 1'b0, 24'h000000, 1'b0},
    '{ROW_CFG,  OP_UPDATE, CFG_AVG_COUNT, 24'h000000, 32'd0,        1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'h123456, 32'd4000,     1'b1, 24'h123456, 1'b1},
    '{ROW_CFG,  OP_UPDATE, CFG_AVG_COUNT, 24'h000000, 32'd2,        1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_UPDATE, CFG_MAX_AGE,   24'hFFFFFE, 32'd4001,     1'b0, 24'h000000, 1'b0},
    '{ROW_CFG,  OP_UPDATE, CFG_MAX_AGE,   24'h000000, 32'd1,        1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'd4002,     1'b0, 24'h000000, 1'b0},
    '{ROW_ITEM, OP_STEP,   CFG_MAX_AGE,   24'h000000, 32'd4003,     1'b1, 24'h000000, 1'b0}
  };

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  cfg_idx_t                 cfg_index  = CFG_MAX_AGE;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata   = '0;  // sample, time_ms, zero pad
  op_t                      in_tuser   = OP_UPDATE;  // op
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_W-1:0]         out_tdata;  // value, zero pad
  logic                     out_tuser;  // valid_res

  // Filter model state, kept at the block's widths.
  q_t             win_mem [DEPTH];
  logic [IDX_W-1:0] win_wr   = '0;
  logic [4:0]     win_fill   = '0;
  logic [4:0]     avg_n      = '0;
  age_t           max_age    = '0;
  q_t             cur_value  = '0;
  logic           cur_set    = 1'b0;
  ms_t            last_ms    = '0;

  reading_t readings_due [$];
  logic     given_typed = 1'b0;
  reading_t given_want  = '0;
  logic     jitter      = 1'b1;
  int       mismatches  = 0;
  int       cycles      = 0;

  windowed_average_with_timeout DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void drop_value();
    cur_set   = 1'b0;
    cur_value = '0;
    win_wr    = '0;
    win_fill  = '0;
  endfunction

  function automatic void apply_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_MAX_AGE:   max_age = data[AGE_BITS-1:0];
      CFG_AVG_COUNT: avg_n = (data[4:0] > DEPTH) ? 5'(DEPTH) : data[4:0];
      default: ;
    endcase
  endfunction

  function automatic reading_t filter_next(op_t op, q_t smp, ms_t t);
    longint acc;
    int     n;
    int     i;
    ms_t    age;
    logic [IDX_W-1:0] idx;
    case (op)
      OP_UPDATE: begin
        if (avg_n == 0) begin
          cur_value = smp;
        end else begin
          win_mem[win_wr] = smp;
          win_wr = win_wr + 1'b1;
          if (win_fill < avg_n) win_fill = win_fill + 1'b1;
          n = int'((win_fill < avg_n) ? win_fill : avg_n);
          acc = 0;
          // Newest n entries, oldest first; the index wraps at the ring depth.
          for (i = 0; i < n; i++) begin
            idx = IDX_W'(win_wr - n + i);
            acc += win_mem[idx];
          end
          acc = acc / n;
          cur_value = acc[SW-1:0];
        end
        last_ms = t;
        cur_set = 1'b1;
      end
      OP_STEP: begin
        if (max_age != 0) begin
          age = t - last_ms;
          // A negative age in 32-bit wrapping arithmetic never expires.
          if (!age[TIME_BITS-1] && age > max_age) drop_value();
        end
      end
      OP_CLEAR: drop_value();
      default: ;
    endcase
    return '{cur_value, cur_set};
  endfunction

  always @(posedge clk) begin : scoreboard
    reading_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result value %h flag %b", $time,
                   out_tdata[SW-1:0], out_tuser);
        end else begin
          want = readings_due.pop_front();
          if (out_tdata[SW-1:0] !== want.value) begin
            mismatches++;
            $display("%0t: value expected %h, got %h", $time, want.value,
                     out_tdata[SW-1:0]);
          end
          if (out_tuser !== want.flag) begin
            mismatches++;
            $display("%0t: valid flag expected %b, got %b", $time, want.flag, out_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        want = filter_next(in_tuser, in_tdata[SW-1:0], in_tdata[SW +: TIME_BITS]);
        readings_due.push_back(given_typed ? given_want : want);
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= jitter ? ($urandom_range(0, 99) >= 28) : 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_item(op_t op, q_t smp, ms_t t, logic typed, q_t wv, logic wf);
    @(negedge clk);
    while (jitter && $urandom_range(0, 99) < 28) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid   = 1'b1;
    in_tuser    = op;
    in_tdata    = IN_W'({t, smp});
    given_typed = typed;
    given_want  = '{wv, wf};
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the input back until every result has left the block.
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int i;
    int ph;
    int r;
    op_t op;
    q_t smp;
    ms_t t;
    ms_t now_ms;
    int unsigned span;
    logic [CFG_DATA_BITS-1:0] age_cfg;
    logic [CFG_DATA_BITS-1:0] avg_cfg;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        wait_drain();
        write_cfg(PLAN[i].idx, PLAN[i].t[CFG_DATA_BITS-1:0]);
      end else begin
        send_item(PLAN[i].op, PLAN[i].smp, PLAN[i].t, PLAN[i].typed, PLAN[i].wv, PLAN[i].wf);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          age_cfg = '0;
          avg_cfg = 31'd16;
        end
        1: begin
          age_cfg = 31'd1;
          avg_cfg = 31'd1;
        end
        2: begin
          age_cfg = 31'h7FFFFFFF;
          avg_cfg = 31'd5;
        end
        3: begin
          age_cfg = CFG_DATA_BITS'($urandom_range(1, 200));
          avg_cfg = CFG_DATA_BITS'($urandom_range(0, 31));
        end
        4: begin
          age_cfg = CFG_DATA_BITS'($urandom());
          avg_cfg = CFG_DATA_BITS'($urandom());
        end
        5: begin
          age_cfg = 31'd50;
          avg_cfg = 31'd16;
        end
        6: begin
          age_cfg = CFG_DATA_BITS'($urandom_range(1, 5000));
          avg_cfg = 31'd3;
        end
        default: begin
          age_cfg = '0;
          avg_cfg = '0;
        end
      endcase
      wait_drain();
      // One phase runs with both sides always ready.
      jitter = (ph != 5);
      write_cfg(CFG_MAX_AGE, age_cfg);
      write_cfg(CFG_AVG_COUNT, avg_cfg);
      now_ms = $urandom();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55)      op = OP_UPDATE;
        else if (r < 85) op = OP_STEP;
        else if (r < 93) op = OP_CLEAR;
        else             op = OP_UNUSED;

        r = $urandom_range(0, 9);
        if (r == 0)     smp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        else if (r < 3) smp = q_t'($urandom_range(0, 8) - 4);
        else            smp = q_t'($urandom());

        r = $urandom_range(0, 99);
        if (op == OP_STEP && max_age != 0 && r < 40) begin
          // Land right around the expiry boundary of the last update.
          t = last_ms + max_age - 1 + $urandom_range(0, 2);
        end else if (r >= 95) begin
          t = $urandom();
        end else begin
          span = (max_age == 0) ? 1000 : max_age + (max_age >> 1) + 1;
          now_ms = now_ms + $urandom_range(0, span);
          t = now_ms;
        end

        if ($urandom_range(0, 99) == 0) wait_drain();
        send_item(op, smp, t, 1'b0, '0, 1'b0);
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
